// ===== src/oass_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered array shift store package
// Shared defaults, command and error codes, controller states and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package oass_pkg;

  localparam int DEFAULT_DEPTH     = 16;
  localparam int DEFAULT_WORD_BITS = 32;

  localparam int CMD_BITS = 3;
  localparam int ERR_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_RESIZE = 3'd6
  } cmd_t;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;   // latch the incoming command into the datapath
    logic execute;   // apply the latched command and load the result register
  } dp_cmd_t;

endpackage

// ===== src/ordered_array_shift_store.sv =====
// ----------------------------------------------------------------------------
// Ordered array shift store
// Fixed-capacity ordered word array with push, pop, insert, erase, read,
// clear and resize commands, each answered by one result transfer.
// ----------------------------------------------------------------------------
// Each command is latched into the command latch on its input transfer, then
// applied to the entry register chain, which shifts the affected entries up
// or down at once, while the result register is loaded. The block takes one
// command at a time, so it does not accept a new command until the last one
// has been applied and its result slot will be free. A result waiting on the
// output does not stop the next command from being accepted in the same cycle
// that the result transfer completes. There is no clearing pass after reset;
// entries at or beyond the length are never returned.
module ordered_array_shift_store #(
  parameter int  DEPTH     = oass_pkg::DEFAULT_DEPTH,
  parameter int  WORD_BITS = oass_pkg::DEFAULT_WORD_BITS,
  localparam int PW        = $clog2(DEPTH + 1),
  localparam int IN_BITS   = oass_pkg::CMD_BITS + PW + WORD_BITS + PW,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = WORD_BITS + PW + 1 + oass_pkg::ERR_BITS,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command, position, word_in, new_length
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // word_out, length, is_empty, error
);
  import oass_pkg::*;

  dp_cmd_t              dp_cmd;
  logic [WORD_BITS-1:0] word_out;
  logic [PW-1:0]        length;
  logic                 is_empty;
  logic [ERR_BITS-1:0]  error;

  oass_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dp_cmd   (dp_cmd)
  );

  oass_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .PW        (PW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .command    (s_tdata[CMD_BITS-1:0]),
    .position   (s_tdata[CMD_BITS +: PW]),
    .word_in    (s_tdata[CMD_BITS+PW +: WORD_BITS]),
    .new_length (s_tdata[CMD_BITS+PW+WORD_BITS +: PW]),
    .word_out   (word_out),
    .length     (length),
    .is_empty   (is_empty),
    .error      (error)
  );

  assign m_tdata = OUT_W'({error, is_empty, length, word_out});

endmodule

// ===== src/oass_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordered array shift store controller
// Sequences each command: capture on an input transfer, execute on the next
// cycle, then hold the result until the output transfer completes.
// ----------------------------------------------------------------------------
module oass_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output oass_pkg::dp_cmd_t dp_cmd
);
  import oass_pkg::*;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next     = state;
    dp_cmd.capture = 1'b0;
    dp_cmd.execute = 1'b0;
    s_tready       = 1'b0;
    m_tvalid_next  = m_tvalid && !m_tready;
    unique case (state)
      ST_IDLE: begin
        // A new command is taken only once the result slot will be free.
        s_tready = !m_tvalid || m_tready;
        if (s_tvalid && s_tready) begin
          dp_cmd.capture = 1'b1;
          state_next     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dp_cmd.execute = 1'b1;
        m_tvalid_next  = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_exec_slot_free: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.execute |-> !m_tvalid)
    else $error("result register loaded while a result is pending");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.execute |=> m_tvalid)
    else $error("executed command produced no result");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> dp_cmd.execute)
    else $error("accepted command was not executed next cycle");
`endif

endmodule

// ===== src/oass_dp.sv =====
// ----------------------------------------------------------------------------
// Ordered array shift store datapath
// Entry register chain with parallel shift up or down, the length register,
// the command latch and the result register.
// ----------------------------------------------------------------------------
module oass_dp #(
  parameter int DEPTH     = oass_pkg::DEFAULT_DEPTH,
  parameter int WORD_BITS = oass_pkg::DEFAULT_WORD_BITS,
  parameter int PW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  oass_pkg::dp_cmd_t             dp_cmd,
  input  logic [oass_pkg::CMD_BITS-1:0] command,
  input  logic [PW-1:0]                 position,
  input  logic [WORD_BITS-1:0]          word_in,
  input  logic [PW-1:0]                 new_length,
  output logic [WORD_BITS-1:0]          word_out,
  output logic [PW-1:0]                 length,
  output logic                          is_empty,
  output logic [oass_pkg::ERR_BITS-1:0] error
);
  import oass_pkg::*;

  localparam logic [PW-1:0] DEPTH_L = PW'(DEPTH);

  cmd_t                 cmd_q;
  logic [PW-1:0]        pos_q;
  logic [WORD_BITS-1:0] word_q;
  logic [PW-1:0]        target_q;

  logic [WORD_BITS-1:0] entries      [DEPTH];
  logic [WORD_BITS-1:0] entries_next [DEPTH];
  logic [PW-1:0]        used;
  logic [PW-1:0]        used_next;
  err_t                 err;
  logic [WORD_BITS-1:0] rd;
  logic                 full;

  assign full = (used == DEPTH_L);

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q    <= cmd_t'(command);
      pos_q    <= position;
      word_q   <= word_in;
      target_q <= new_length;
    end
  end

  always_comb begin
    entries_next = entries;
    used_next    = used;
    err          = ERR_OK;
    rd           = '0;
    unique case (cmd_q)
      CMD_PUSH: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (PW'(i) == used) entries_next[i] = word_q;
          end
          used_next = used + PW'(1);
        end
      end
      CMD_POP: begin
        if (used != '0) used_next = used - PW'(1);
      end
      CMD_INSERT: begin
        if (pos_q > used) begin
          err = ERR_RANGE;
        end else if (full) begin
          err = ERR_FULL;
        end else begin
          // Entries from the position up to the end move up one slot.
          for (int i = 1; i < DEPTH; i++) begin
            if (PW'(i) > pos_q && PW'(i) <= used) entries_next[i] = entries[i-1];
          end
          for (int i = 0; i < DEPTH; i++) begin
            if (PW'(i) == pos_q) entries_next[i] = word_q;
          end
          used_next = used + PW'(1);
        end
      end
      CMD_ERASE: begin
        if (pos_q >= used) begin
          err = ERR_RANGE;
        end else begin
          // Slots past the end may take stale data; they are never read.
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (PW'(i) >= pos_q) entries_next[i] = entries[i+1];
          end
          used_next = used - PW'(1);
        end
      end
      CMD_READ: begin
        if (pos_q >= used) begin
          err = ERR_RANGE;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (PW'(i) == pos_q) rd = entries[i];
          end
        end
      end
      CMD_CLEAR: begin
        used_next = '0;
      end
      CMD_RESIZE: begin
        if (target_q > DEPTH_L) begin
          err = ERR_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (PW'(i) >= used && PW'(i) < target_q) entries_next[i] = '0;
          end
          used_next = target_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      entries  <= entries_next;
      word_out <= rd;
      length   <= used_next;
      is_empty <= (used_next == '0);
      error    <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (dp_cmd.execute) begin
      used <= used_next;
    end
  end

`ifndef SYNTHESIS
  a_used_in_range: assert property (@(posedge clk) disable iff (rst)
    used <= DEPTH_L)
    else $error("length exceeds capacity");

  a_error_keeps_length: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.execute && err != ERR_OK |=> used == $past(used))
    else $error("length changed on a failed command");

  a_result_length: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.execute |=> length == used && is_empty == (used == '0))
    else $error("result length does not match the length register");
`endif

endmodule
